FILE: sv/csa_pkg.sv
package csa_pkg;

  localparam int BODY_COUNT = 1024;
  localparam int ADDR_W     = $clog2(BODY_COUNT);
  localparam int BODY_W     = 10;
  localparam int SUM_W      = 40;
  localparam int TERM_W     = 32;

  localparam logic [SUM_W-1:0] SUM_MAX    = '1;
  localparam logic [30:0]      ONE_Q30    = 31'h4000_0000;
  localparam logic [47:0]      ROUND_HALF = 48'h4000;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic [2:0][TERM_W-1:0] trans;
    logic [2:0][TERM_W-1:0] rot;
  } terms_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] trans;
    logic [2:0][SUM_W-1:0] rot;
  } sums_t;

endpackage

FILE: sv/csa_ram.sv
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/csa_terms.sv
module csa_terms
  import csa_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] nx,
  input  logic signed [15:0] ny,
  input  logic signed [15:0] nz,
  input  logic        [15:0] kn,
  input  logic        [15:0] ks,
  output terms_t             terms
);

  // Three registered stages: squares, products, rounding.
  logic signed [2:0][31:0] sq_full;
  logic [2:0][30:0]        sq_r;
  logic [2:0][46:0]        tk_r;
  logic [2:0][46:0]        ts_r;
  logic [2:0][47:0]        rp_r;
  terms_t                  terms_nxt;
  terms_t                  terms_r;

  assign sq_full[0] = nx * nx;
  assign sq_full[1] = ny * ny;
  assign sq_full[2] = nz * nz;

  always_comb begin
    logic [47:0] tsum;
    logic [47:0] rsum;
    terms_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      tsum = {1'b0, tk_r[i]} + {1'b0, ts_r[i]} + ROUND_HALF;
      rsum = rp_r[i] + ROUND_HALF;
      terms_nxt.trans[i] = tsum[46:15];
      terms_nxt.rot[i]   = rsum[46:15];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_full[i][30:0];
      tk_r[i] <= 47'(sq_r[i]) * 47'(kn);
      ts_r[i] <= 47'(ONE_Q30 - sq_r[i]) * 47'(ks);
    end
    rp_r[0] <= (48'(sq_r[1]) + 48'(sq_r[2])) * 48'(ks);
    rp_r[1] <= (48'(sq_r[0]) + 48'(sq_r[2])) * 48'(ks);
    rp_r[2] <= (48'(sq_r[0]) + 48'(sq_r[1])) * 48'(ks);
    terms_r <= terms_nxt;
  end

  assign terms = terms_r;

endmodule

FILE: sv/contact_stiffness_accumulator.sv
// Accumulate transaction: busy through S_SQ, S_MUL, S_RND, S_WA and S_WB after acceptance, no result.
// An ignored contact leaves busy low, so the next transaction can follow at once.
// Read transaction: busy in S_RCLR, which reads and clears the body; the result strobe follows in the cycle after.
// Throughput is one transaction at a time, set by the read-modify-write of two bodies.
// After reset the sums are cleared in a pass over all BODY_COUNT (1024) addresses with busy high.
// Results are shown for one cycle on out_valid; the receiver cannot stall them.
module contact_stiffness_accumulator
  import csa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_op,
  input  logic [BODY_W-1:0]       in_body_a,
  input  logic [BODY_W-1:0]       in_body_b,
  input  logic signed [15:0]      in_normal_x,
  input  logic signed [15:0]      in_normal_y,
  input  logic signed [15:0]      in_normal_z,
  input  logic [15:0]             in_normal_stiffness,
  input  logic [15:0]             in_shear_stiffness,
  input  logic                    in_contact_real,
  input  logic                    in_force_nonzero,
  output logic                    out_valid,
  output logic [BODY_W-1:0]       out_body_id,
  output logic [SUM_W-1:0]        out_trans_x,
  output logic [SUM_W-1:0]        out_trans_y,
  output logic [SUM_W-1:0]        out_trans_z,
  output logic [SUM_W-1:0]        out_rot_x,
  output logic [SUM_W-1:0]        out_rot_y,
  output logic [SUM_W-1:0]        out_rot_z
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SQ, S_MUL, S_RND, S_WA, S_WB, S_RCLR
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [BODY_W-1:0]   body_a_r;
  logic [BODY_W-1:0]   body_b_r;
  logic signed [15:0]  nx_r;
  logic signed [15:0]  ny_r;
  logic signed [15:0]  nz_r;
  logic [15:0]         kn_r;
  logic [15:0]         ks_r;
  sums_t               sum_a_r;
  sums_t               out_sums_r;
  logic [BODY_W-1:0]   out_body_r;
  logic                out_valid_r;

  terms_t              terms;
  sums_t               rdata;
  sums_t               sum_a_nxt;
  sums_t               sum_b_nxt;
  logic                accept;
  logic                a_ok;
  logic                b_ok;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  sums_t               ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;

  function automatic sums_t add_sums(sums_t base, terms_t t);
    sums_t       res;
    logic [SUM_W:0] s;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, base.trans[i]} + (SUM_W + 1)'(t.trans[i]);
      res.trans[i] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
      s = {1'b0, base.rot[i]} + (SUM_W + 1)'(t.rot[i]);
      res.rot[i] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    end
    return res;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign a_ok   = (32'(body_a_r) < 32'(BODY_COUNT));
  assign b_ok   = (32'(body_b_r) < 32'(BODY_COUNT));

  assign sum_a_nxt = add_sums(rdata, terms);
  assign sum_b_nxt = add_sums((body_b_r == body_a_r) ? sum_a_r : rdata, terms);

  csa_terms u_terms (
    .clk   (clk),
    .nx    (nx_r),
    .ny    (ny_r),
    .nz    (nz_r),
    .kn    (kn_r),
    .ks    (ks_r),
    .terms (terms)
  );

  csa_ram #(
    .WIDTH ($bits(sums_t)),
    .DEPTH (BODY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(body_a_r);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(body_a_r);
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      S_IDLE: begin
        ram_re    = accept && (in_op == OP_READ);
        ram_raddr = ADDR_W'(in_body_a);
      end
      S_RND: begin
        ram_re = 1'b1;
      end
      S_WA: begin
        ram_we    = a_ok;
        ram_wdata = sum_a_nxt;
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(body_b_r);
      end
      S_WB: begin
        ram_we    = b_ok;
        ram_waddr = ADDR_W'(body_b_r);
        ram_wdata = sum_b_nxt;
      end
      S_RCLR: begin
        ram_we = a_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(BODY_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            body_a_r <= in_body_a;
            body_b_r <= in_body_b;
            nx_r     <= in_normal_x;
            ny_r     <= in_normal_y;
            nz_r     <= in_normal_z;
            kn_r     <= in_normal_stiffness;
            ks_r     <= in_shear_stiffness;
            if (in_op == OP_READ) begin
              state_r <= S_RCLR;
            end else if (in_contact_real && in_force_nonzero) begin
              state_r <= S_SQ;
            end
          end
        end
        S_SQ:  state_r <= S_MUL;
        S_MUL: state_r <= S_RND;
        S_RND: state_r <= S_WA;
        S_WA: begin
          sum_a_r <= sum_a_nxt;
          state_r <= S_WB;
        end
        S_WB: state_r <= S_IDLE;
        S_RCLR: begin
          out_valid_r <= 1'b1;
          out_body_r  <= body_a_r;
          out_sums_r  <= a_ok ? rdata : '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_body_id = out_body_r;
  assign out_trans_x = out_sums_r.trans[0];
  assign out_trans_y = out_sums_r.trans[1];
  assign out_trans_z = out_sums_r.trans[2];
  assign out_rot_x   = out_sums_r.rot[0];
  assign out_rot_y   = out_sums_r.rot[1];
  assign out_rot_z   = out_sums_r.rot[2];

  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_RCLR))
    else $error("result strobe without a read transaction");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_READ) |=> (busy && !out_valid) ##1 out_valid)
    else $error("read transaction did not produce one result");

endmodule

FILE: sim/tb_contact_stiffness_accumulator.sv
`timescale 1ns / 1ps

module tb_contact_stiffness_accumulator;
  import csa_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SAT_RUN    = 260;
  localparam int RANDOM_RUN = 280;

  typedef struct {
    logic              op;
    logic [BODY_W-1:0] body_a;
    logic [BODY_W-1:0] body_b;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]       kn;
    logic [15:0]       ks;
    logic              contact_real;
    logic              force_nonzero;
  } txn_t;

  typedef struct {
    logic [BODY_W-1:0] body_id;
    sums_t             sums;
  } report_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_op;
  logic [BODY_W-1:0] in_body_a;
  logic [BODY_W-1:0] in_body_b;
  logic signed [15:0] in_normal_x;
  logic signed [15:0] in_normal_y;
  logic signed [15:0] in_normal_z;
  logic [15:0]       in_normal_stiffness;
  logic [15:0]       in_shear_stiffness;
  logic              in_contact_real;
  logic              in_force_nonzero;
  logic              out_valid;
  logic [BODY_W-1:0] out_body_id;
  logic [SUM_W-1:0]  out_trans_x;
  logic [SUM_W-1:0]  out_trans_y;
  logic [SUM_W-1:0]  out_trans_z;
  logic [SUM_W-1:0]  out_rot_x;
  logic [SUM_W-1:0]  out_rot_y;
  logic [SUM_W-1:0]  out_rot_z;

  contact_stiffness_accumulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_body_a           (in_body_a),
    .in_body_b           (in_body_b),
    .in_normal_x         (in_normal_x),
    .in_normal_y         (in_normal_y),
    .in_normal_z         (in_normal_z),
    .in_normal_stiffness (in_normal_stiffness),
    .in_shear_stiffness  (in_shear_stiffness),
    .in_contact_real     (in_contact_real),
    .in_force_nonzero    (in_force_nonzero),
    .out_valid           (out_valid),
    .out_body_id         (out_body_id),
    .out_trans_x         (out_trans_x),
    .out_trans_y         (out_trans_y),
    .out_trans_z         (out_trans_z),
    .out_rot_x           (out_rot_x),
    .out_rot_y           (out_rot_y),
    .out_rot_z           (out_rot_z)
  );

  bit [2:0][SUM_W-1:0] trans_acc [BODY_COUNT];
  bit [2:0][SUM_W-1:0] rot_acc [BODY_COUNT];

  txn_t    txn_queue[$];
  report_t sums_expected[$];
  txn_t    cur_txn;

  bit took;
  bit burst_mode;
  int gap_left;
  int idle_cycles;
  int n_queued;
  int n_accepted;
  int n_contacts;
  int n_ignored;
  int n_reads;
  int n_saturated;
  int n_errors;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit [SUM_W-1:0] round_q15(longint v30);
    return SUM_W'((v30 + longint'(ROUND_HALF)) >> 15);
  endfunction

  function automatic bit [SUM_W-1:0] sat_sum(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
    bit [SUM_W:0] s;
    s = a + b;
    return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic void add_terms(logic [BODY_W-1:0] body, bit [2:0][SUM_W-1:0] t,
                                    bit [2:0][SUM_W-1:0] r);
    for (int i = 0; i < 3; i++) begin
      trans_acc[body][i] = sat_sum(trans_acc[body][i], t[i]);
      rot_acc[body][i]   = sat_sum(rot_acc[body][i], r[i]);
    end
  endfunction

  function automatic void update_body_sums(txn_t tr);
    longint              sq[3];
    longint              kn;
    longint              ks;
    bit [2:0][SUM_W-1:0] t;
    bit [2:0][SUM_W-1:0] r;
    report_t             rep;
    if (tr.op == OP_READ) begin
      rep.body_id = tr.body_a;
      for (int i = 0; i < 3; i++) begin
        rep.sums.trans[i] = trans_acc[tr.body_a][i];
        rep.sums.rot[i]   = rot_acc[tr.body_a][i];
      end
      trans_acc[tr.body_a] = '0;
      rot_acc[tr.body_a]   = '0;
      sums_expected.push_back(rep);
      return;
    end
    n_contacts++;
    if (!(tr.contact_real && tr.force_nonzero)) begin
      n_ignored++;
      return;
    end
    kn    = longint'(tr.kn);
    ks    = longint'(tr.ks);
    sq[0] = longint'(tr.nx) * longint'(tr.nx);
    sq[1] = longint'(tr.ny) * longint'(tr.ny);
    sq[2] = longint'(tr.nz) * longint'(tr.nz);
    for (int i = 0; i < 3; i++) begin
      t[i] = round_q15(sq[i] * kn + (longint'(ONE_Q30) - sq[i]) * ks);
    end
    r[0] = round_q15((sq[1] + sq[2]) * ks);
    r[1] = round_q15((sq[0] + sq[2]) * ks);
    r[2] = round_q15((sq[0] + sq[1]) * ks);
    add_terms(tr.body_a, t, r);
    add_terms(tr.body_b, t, r);
  endfunction

  function automatic logic [BODY_W-1:0] pick_body();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return BODY_W'($urandom_range(0, 15));
    end else if (r < 80) begin
      return BODY_W'(BODY_COUNT - 1);
    end
    return BODY_W'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return 16'sh7fff;
    end else if (r < 6) begin
      return -16'sh8000;
    end else if (r < 9) begin
      return 16'sh0000;
    end else if (r < 11) begin
      return -16'sh0001;
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_stiffness();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return 16'h0000;
    end else if (r < 10) begin
      return 16'hffff;
    end
    return 16'($urandom);
  endfunction

  function automatic txn_t random_txn();
    txn_t tr;
    tr.op            = ($urandom_range(0, 99) < 22) ? OP_READ : OP_ACCUM;
    tr.body_a        = pick_body();
    tr.body_b        = pick_body();
    tr.nx            = pick_component();
    tr.ny            = pick_component();
    tr.nz            = pick_component();
    tr.kn            = pick_stiffness();
    tr.ks            = pick_stiffness();
    tr.contact_real  = ($urandom_range(0, 99) < 90);
    tr.force_nonzero = ($urandom_range(0, 99) < 90);
    return tr;
  endfunction

  function automatic void queue_contact(int ba, int bb, int nx, int ny, int nz, int kn, int ks,
                                        bit creal, bit fnz);
    txn_t tr;
    tr.op            = OP_ACCUM;
    tr.body_a        = BODY_W'(ba);
    tr.body_b        = BODY_W'(bb);
    tr.nx            = 16'(nx);
    tr.ny            = 16'(ny);
    tr.nz            = 16'(nz);
    tr.kn            = 16'(kn);
    tr.ks            = 16'(ks);
    tr.contact_real  = creal;
    tr.force_nonzero = fnz;
    txn_queue.push_back(tr);
  endfunction

  function automatic void queue_read(int body);
    txn_t tr;
    tr        = random_txn();
    tr.op     = OP_READ;
    tr.body_a = BODY_W'(body);
    txn_queue.push_back(tr);
  endfunction

  function automatic int next_gap();
    int r;
    if ($urandom_range(0, 39) == 0) begin
      burst_mode = !burst_mode;
    end
    if (burst_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string what, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (txn_queue.size() > 0) begin
        cur_txn = txn_queue.pop_front();
        in_op               <= cur_txn.op;
        in_body_a           <= cur_txn.body_a;
        in_body_b           <= cur_txn.body_b;
        in_normal_x         <= cur_txn.nx;
        in_normal_y         <= cur_txn.ny;
        in_normal_z         <= cur_txn.nz;
        in_normal_stiffness <= cur_txn.kn;
        in_shear_stiffness  <= cur_txn.ks;
        in_contact_real     <= cur_txn.contact_real;
        in_force_nonzero    <= cur_txn.force_nonzero;
        start               <= 1'b1;
        gap_left = next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    report_t exp_rep;
    took = rst_n && start && (busy === 1'b0);
    if (took) begin
      update_body_sums(cur_txn);
      n_accepted++;
    end
    if (rst_n && out_valid === 1'b1) begin
      n_reads++;
      if (sums_expected.size() == 0) begin
        $display("%0t: result for body %0d with no transaction waiting", $time, out_body_id);
        n_errors++;
      end else begin
        exp_rep = sums_expected.pop_front();
        check_field("body_id", SUM_W'(exp_rep.body_id), SUM_W'(out_body_id));
        check_field("trans_x", exp_rep.sums.trans[0], out_trans_x);
        check_field("trans_y", exp_rep.sums.trans[1], out_trans_y);
        check_field("trans_z", exp_rep.sums.trans[2], out_trans_z);
        check_field("rot_x", exp_rep.sums.rot[0], out_rot_x);
        check_field("rot_y", exp_rep.sums.rot[1], out_rot_y);
        check_field("rot_z", exp_rep.sums.rot[2], out_rot_z);
        if (exp_rep.sums.trans[0] == SUM_MAX || exp_rep.sums.rot[0] == SUM_MAX) begin
          n_saturated++;
        end
      end
    end
    if (took || (rst_n && out_valid === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_contact_stiffness_accumulator: errors");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    start               = 1'b0;
    in_op               = OP_ACCUM;
    in_body_a           = '0;
    in_body_b           = '0;
    in_normal_x         = '0;
    in_normal_y         = '0;
    in_normal_z         = '0;
    in_normal_stiffness = '0;
    in_shear_stiffness  = '0;
    in_contact_real     = 1'b0;
    in_force_nonzero    = 1'b0;

    queue_read(0);
    queue_contact(0, 1, 32767, 0, 0, 65535, 65535, 1, 1);
    queue_contact(1023, 1023, -32768, -32768, -32768, 65535, 65535, 1, 1);
    queue_contact(2, 3, 0, 0, 0, 0, 65535, 1, 1);
    queue_contact(2, 0, 23170, -23170, 0, 1000, 300, 1, 1);
    queue_contact(3, 3, 0, 32767, -32768, 0, 0, 1, 1);
    queue_contact(4, 5, 1, -1, 16384, 65535, 1, 1, 1);
    queue_contact(0, 1, 32767, 32767, 32767, 65535, 65535, 0, 1);
    queue_contact(4, 5, -32768, 100, 200, 65535, 65535, 1, 0);
    queue_contact(2, 3, 5, 6, 7, 8, 9, 0, 0);
    for (int b = 0; b < 6; b++) begin
      queue_read(b);
    end
    queue_read(1023);
    queue_read(0);

    // Hammer one body until every sum sits at the ceiling, then read it out.
    for (int i = 0; i < SAT_RUN; i++) begin
      queue_contact(600, 600, -32768, -32768, -32768, 65535, 65535, 1, 1);
    end
    queue_read(600);
    queue_read(600);

    for (int i = 0; i < RANDOM_RUN; i++) begin
      txn_queue.push_back(random_txn());
    end
    for (int b = 0; b < 16; b++) begin
      queue_read(b);
    end
    n_queued = txn_queue.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_queued) @(posedge clk);
    while (sums_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d contacts (%0d ignored) and %0d body reads with results checked,",
             n_contacts, n_ignored, n_reads);
    $display("including extreme normals, repeated bodies and %0d saturated read-outs.",
             n_saturated);
    if (n_errors == 0 && sums_expected.size() == 0) begin
      $display("tb_contact_stiffness_accumulator: clean");
    end else begin
      $display("tb_contact_stiffness_accumulator: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/csa_pkg.sv
sv/csa_ram.sv
sv/csa_terms.sv
sv/contact_stiffness_accumulator.sv
sim/tb_contact_stiffness_accumulator.sv
